// ===== hw/rtl/gf2rk_pkg.sv =====
// ----------------------------------------------------------------------------
// gf2rk_pkg
// Shared constants and types for the GF(2) rank / XOR-basis block.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2rk_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int ROW_BITS      = 32;
   localparam int RANK_BITS     = 6;
   localparam int RSP_BITS      = 8;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gf2_rank_xor_basis_top.sv =====
// ----------------------------------------------------------------------------
// gf2_rank_xor_basis_top
// Incremental GF(2) rank: each row word is reduced against a pivot file by
// XOR, one bit position per cycle from the top down; a row that keeps a bit
// without a pivot becomes a new pivot and raises the rank.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata[31:0] row_bits, tuser start_new
//  rsp      out  rsp_tvalid/rsp_tready  tdata[0] independent, [6:1] rank_so_far
//
//  Each word is accepted in IDLE, then scanned from the top bit down in SCAN
//  by the shared XOR step (stops early when the row goes to zero or a pivot
//  is stored), then DONE loads the result register. req_tready is high only
//  when idle. The result holds in its register until taken; a finished word
//  waits in DONE while the previous result is unread. Reset clears rank and
//  all pivot valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_rank_xor_basis_top
   import gf2rk_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ROW_BITS-1:0]   req_tdata,   // [31:0] row_bits
   input  wire logic                  req_tuser,   // [0] start_new
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_BITS-1:0]        rsp_tdata    // [0] independent, [6:1] rank_so_far
);

   localparam int RowW = (WORD_BITS < ROW_BITS) ? WORD_BITS : ROW_BITS;
   localparam int IdxW = $clog2(RowW);

   state_type             state_ff, state_in;
   logic [RowW-1:0]       row_ff, row_in;
   logic [IdxW-1:0]       bit_ff, bit_in;
   logic [RowW-1:0]       valid_ff, valid_in;
   logic [RowW-1:0]       pivot_ff [RowW];
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   logic                  indep_ff, indep_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                  piv_we;
   logic [RowW-1:0]       row_xor;
   logic                  accept;
   logic                  slot_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign row_xor    = row_ff ^ pivot_ff[bit_ff];

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      bit_in       = bit_ff;
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      indep_in     = indep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      piv_we       = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in   = req_tdata[RowW-1:0];
               bit_in   = IdxW'(RowW - 1);
               indep_in = 1'b0;
               if (req_tuser) begin
                  valid_in = '0;
                  rank_in  = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one bit position per cycle; XOR only touches bits at or below it
            if (row_ff == '0) begin
               state_in = ST_DONE;
            end else if (row_ff[bit_ff]) begin
               if (valid_ff[bit_ff]) begin
                  row_in = row_xor;
                  if (row_xor == '0 || bit_ff == '0) begin
                     state_in = ST_DONE;
                  end
               end else begin
                  piv_we           = 1'b1;
                  valid_in[bit_ff] = 1'b1;
                  rank_in          = rank_ff + RANK_BITS'(1);
                  indep_in         = 1'b1;
                  state_in         = ST_DONE;
               end
            end else if (bit_ff == '0) begin
               state_in = ST_DONE;
            end
            bit_in = bit_ff - IdxW'(1);
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_BITS - RANK_BITS - 1){1'b0}}, rank_ff, indep_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      bit_ff      <= bit_in;
      indep_ff    <= indep_in;
      rsp_data_ff <= rsp_data_in;
      if (piv_we) begin
         pivot_ff[bit_ff] <= row_ff;
      end
   end

   // rank always matches the number of stored pivots
   a_rank_pivots: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(rank_ff))
      else $error("rank out of step with pivot valid bits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted a word while busy");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (rank_ff == '0 && valid_ff == '0))
      else $error("start did not clear the basis");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      int'(rank_ff) <= RowW)
      else $error("rank exceeds row width");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for gf2_rank_xor_basis_top. Row words go in on the req
// stream and one status word comes back per row on the rsp stream. A bench
// XOR-basis model predicts the independent flag and the running rank; typed
// rows of the short directed table, which runs first, expect its values.
// Random sets of 1 to 60 rows follow, mostly 40 or fewer, mixing random,
// sparse, zero and dependent rows. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import gf2rk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic            indep;
      logic [RANK_BITS-1:0] rank;
   } rank_rsp_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]  row;
      logic                 start;
      logic                 typed;
      logic                 indep;
      logic [RANK_BITS-1:0] rank;
   } dir_stim_type;

   localparam int DIR_LEN = 22;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ROW_BITS-1:0] req_tdata = '0;    // [31:0] row_bits
   logic                req_tuser = 1'b0;  // [0] start_new
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;         // [0] independent, [6:1] rank_so_far

   logic [ROW_BITS-1:0]  basis_rows [ROW_BITS];
   logic [RANK_BITS-1:0] basis_rank;
   rank_rsp_type         expected_rsp_q [$];
   int                   mismatches = 0;
   bit                   sender_calm = 1'b0;
   bit                   receiver_calm = 1'b0;

   // row, start, typed, independent, rank
   dir_stim_type dir_tab [DIR_LEN] = '{
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 6'd0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd1},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd1},
      '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 6'd2},
      '{32'h0000_0001, 1'b0, 1'b1, 1'b1, 6'd3},
      '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd3},
      '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 6'd0},
      '{32'h0000_0001, 1'b1, 1'b1, 1'b1, 6'd1},
      '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 6'd1},
      '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 6'd2},
      '{32'h8000_0001, 1'b0, 1'b1, 1'b0, 6'd2},
      '{32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, 6'd1},
      '{32'h5555_5555, 1'b0, 1'b1, 1'b1, 6'd2},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 6'd2},
      '{32'h1234_5678, 1'b0, 1'b0, 1'b0, 6'd0},
      '{32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 6'd0},
      '{32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 6'd0},
      '{32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 6'd0},
      '{32'h4000_0000, 1'b1, 1'b1, 1'b1, 6'd1},
      '{32'h6000_0000, 1'b0, 1'b1, 1'b1, 6'd2},
      '{32'h0000_0001, 1'b0, 1'b1, 1'b1, 6'd3},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 6'd1}
   };

   gf2_rank_xor_basis_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Reduce a row against the basis, top bit down; store it if a bit survives.
   function automatic rank_rsp_type reduce_row(input logic [ROW_BITS-1:0] row,
                                               input logic start);
      logic [ROW_BITS-1:0] x;
      rank_rsp_type        res;
      x = row;
      res.indep = 1'b0;
      if (start) begin
         for (int i = 0; i < ROW_BITS; i++) basis_rows[i] = '0;
         basis_rank = '0;
      end
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (x[b] && !res.indep) begin
            if (basis_rows[b] != '0) begin
               x = x ^ basis_rows[b];
            end else begin
               basis_rows[b] = x;
               basis_rank = basis_rank + 1'b1;
               res.indep = 1'b1;
            end
         end
      end
      res.rank = basis_rank;
      return res;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_row(input logic [ROW_BITS-1:0] row, input logic start,
                           input rank_rsp_type exp_rsp);
      int gap;
      req_tdata  <= row;
      req_tuser  <= start;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_rsp_q = {expected_rsp_q, exp_rsp};
      @(negedge clock);
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Called at a falling edge; the sender goes idle until every result is in.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      int gap;
      rsp_tready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
         if ($urandom_range(0, 59) == 0) receiver_calm = ~receiver_calm;
         gap = pick_gap(receiver_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rank_rsp_type exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected rsp word %h", $realtime, rsp_tdata);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_tdata[0] !== exp_rsp.indep || rsp_tdata[6:1] !== exp_rsp.rank) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: rsp mismatch indep exp %0b got %0b, rank exp %0d got %0d",
                           $realtime, exp_rsp.indep, rsp_tdata[0], exp_rsp.rank,
                           rsp_tdata[6:1]);
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      logic [ROW_BITS-1:0] set_rows [$];
      logic [ROW_BITS-1:0] row;
      logic                start;
      rank_rsp_type        pred;
      rank_rsp_type        typed_rsp;
      int                  sent;
      int                  set_size;
      int                  kind;

      for (int i = 0; i < ROW_BITS; i++) basis_rows[i] = '0;
      basis_rank = '0;
      sent = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_LEN; i++) begin
         pred = reduce_row(dir_tab[i].row, dir_tab[i].start);
         typed_rsp.indep = dir_tab[i].indep;
         typed_rsp.rank  = dir_tab[i].rank;
         send_row(dir_tab[i].row, dir_tab[i].start, dir_tab[i].typed ? typed_rsp : pred);
         sent++;
      end
      drain_results();

      while (sent < 1090) begin
         set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 60)
                                                : $urandom_range(1, 40);
         sender_calm = ($urandom_range(0, 4) == 0);
         set_rows.delete();
         for (int i = 0; i < set_size; i++) begin
            start = (i == 0) || ($urandom_range(0, 99) < 3);
            if (start) set_rows.delete();
            kind = $urandom_range(0, 99);
            if (kind < 40 || (kind < 60 && set_rows.size() == 0)) begin
               row = $urandom;
            end else if (kind < 60) begin
               // dependent: xor of earlier rows since the last start
               row = '0;
               repeat ($urandom_range(1, 4))
                  row = row ^ set_rows[$urandom_range(0, set_rows.size() - 1)];
            end else if (kind < 75) begin
               row = 32'h1 << $urandom_range(0, 31);
               if ($urandom_range(0, 1)) row = row | (32'h1 << $urandom_range(0, 31));
            end else if (kind < 85) begin
               row = '0;
            end else begin
               row = $urandom >> $urandom_range(0, 31);
            end
            set_rows = {set_rows, row};
            pred = reduce_row(row, start);
            send_row(row, start, pred);
            sent++;
         end
         if ($urandom_range(0, 7) == 0) drain_results();
      end

      drain_results();
      repeat (40) @(negedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/gf2rk_pkg.sv
hw/rtl/gf2_rank_xor_basis_top.sv
tb/tb_top.sv
